### rtl/sm3_pkg.sv
// package: shared types, constants and round functions of the sm3 hash engine
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [255:0] IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // one queued transaction from front to back
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
  } sm3_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

### rtl/sm3_front.sv
// front end: accepts input words, masks the tail and queues them
`default_nettype none
module sm3_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [31:0]         in_message_word,
  input  wire  [2:0]          in_valid_bytes,
  input  wire                 in_final_word,
  output logic                q_valid,
  input  wire                 q_pop,
  output sm3_pkg::sm3_item_t  q_item
);
  import sm3_pkg::*;

  sm3_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  sm3_item_t  cls;
  logic       push;

  always_comb begin
    cls.fin = in_final_word;
    cls.nbytes = (!in_final_word || in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
    case (cls.nbytes)
      3'd0: cls.word = 32'h0;
      3'd1: cls.word = in_message_word & 32'hFF000000;
      3'd2: cls.word = in_message_word & 32'hFFFF0000;
      3'd3: cls.word = in_message_word & 32'hFFFFFF00;
      default: cls.word = in_message_word;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

### rtl/sm3_back.sv
// back end: block buffer, padding, round engine and digest output
`default_nettype none
module sm3_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  output logic                q_pop,
  input  sm3_pkg::sm3_item_t  q_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_digest_index,
  output logic                out_digest_last
);
  import sm3_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state_r;
  logic [31:0]  w_r [16];
  logic [31:0]  cv_r [8];
  logic [31:0]  v_r [8];
  logic [5:0]   rnd_r;
  logic [5:0]   fill_r;
  logic [63:0]  len_r;
  logic         fin_r;     // compression belongs to the final pass
  logic         extra_r;   // a second padding block follows
  logic [2:0]   oidx_r;

  logic [31:0] wj, wj4, wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [6:0]  fill_sum;
  logic [5:0]  pad_pos;
  logic [31:0] padw [16];

  always_comb begin
    wj   = w_r[0];
    wj4  = w_r[4];
    wnew = p1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    tj   = (rnd_r < 6'd16) ? T_LOW : T_HIGH;
    a12  = rotl(v_r[0], 5'd12);
    ss1  = rotl(a12 + v_r[4] + rotl(tj, rnd_r[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    tt1 = ff + v_r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + v_r[7] + ss1 + wj;
  end

  // block with the incoming word stored and padding applied from fill_sum on
  always_comb begin
    fill_sum = {1'b0, fill_r} + {4'd0, q_item.nbytes};
    pad_pos  = fill_sum[5:0];
    for (int i = 0; i < 16; i++) begin
      padw[i] = w_r[i];
      if (i == int'(fill_r[5:2])) padw[i] = q_item.word;
      for (int b = 0; b < 4; b++) begin
        if (4 * i + b > int'(pad_pos)) padw[i][31 - 8 * b -: 8] = 8'h00;
        else if (4 * i + b == int'(pad_pos)) padw[i][31 - 8 * b -: 8] = PAD_BYTE;
      end
    end
  end

  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign out_valid        = (state_r == S_OUT);
  assign out_digest_word  = cv_r[oidx_r];
  assign out_digest_index = oidx_r;
  assign out_digest_last  = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= 6'd0;
      len_r   <= 64'd0;
      rnd_r   <= 6'd0;
      oidx_r  <= 3'd0;
      fin_r   <= 1'b0;
      extra_r <= 1'b0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV[255 - 32 * i -: 32];
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            len_r <= len_r + {58'd0, q_item.nbytes, 3'd0};
            for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
            rnd_r <= 6'd0;
            if (!q_item.fin) begin
              w_r[fill_r[5:2]] <= q_item.word;
              if (fill_sum[6]) begin
                fill_r  <= 6'd0;
                fin_r   <= 1'b0;
                extra_r <= 1'b0;
                state_r <= S_RUN;
              end else begin
                fill_r <= fill_sum[5:0];
              end
            end else if (fill_sum[6]) begin
              // full block first, then a block of padding only
              w_r[fill_r[5:2]] <= q_item.word;
              fill_r  <= 6'd0;
              fin_r   <= 1'b0;
              extra_r <= 1'b1;
              state_r <= S_RUN;
            end else begin
              for (int i = 0; i < 16; i++) w_r[i] <= padw[i];
              if (pad_pos > 6'd55) begin
                fin_r   <= 1'b0;
                extra_r <= 1'b0;
                state_r <= S_RUN;
                fill_r  <= 6'd1; // marks: length block pending
              end else begin
                fill_r  <= 6'd0;
                fin_r   <= 1'b1;
                state_r <= S_LEN;
              end
            end
          end
        end
        S_LEN: begin
          // length includes this last transaction now
          w_r[14] <= len_r[63:32];
          w_r[15] <= len_r[31:0];
          state_r <= S_RUN;
        end
        S_RUN: begin
          v_r[3] <= v_r[2];
          v_r[2] <= rotl(v_r[1], 5'd9);
          v_r[1] <= v_r[0];
          v_r[0] <= tt1;
          v_r[7] <= v_r[6];
          v_r[6] <= rotl(v_r[5], 5'd19);
          v_r[5] <= v_r[4];
          v_r[4] <= p0(tt2);
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= wnew;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            cv_r[0] <= cv_r[0] ^ tt1;
            cv_r[1] <= cv_r[1] ^ v_r[0];
            cv_r[2] <= cv_r[2] ^ rotl(v_r[1], 5'd9);
            cv_r[3] <= cv_r[3] ^ v_r[2];
            cv_r[4] <= cv_r[4] ^ p0(tt2);
            cv_r[5] <= cv_r[5] ^ v_r[4];
            cv_r[6] <= cv_r[6] ^ rotl(v_r[5], 5'd19);
            cv_r[7] <= cv_r[7] ^ v_r[6];
            if (fin_r) begin
              oidx_r  <= 3'd0;
              state_r <= S_OUT;
            end else if (extra_r || fill_r == 6'd1) begin
              state_r <= S_PAD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_PAD: begin
          // final block: padding byte only if not yet placed, then the length
          w_r[0] <= extra_r ? {PAD_BYTE, 24'h0} : 32'h0;
          for (int i = 1; i < 14; i++) w_r[i] <= 32'h0;
          w_r[14] <= len_r[63:32];
          w_r[15] <= len_r[31:0];
          for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
          rnd_r   <= 6'd0;
          fill_r  <= 6'd0;
          extra_r <= 1'b0;
          fin_r   <= 1'b1;
          state_r <= S_RUN;
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) cv_r[i] <= IV[255 - 32 * i -: 32];
              len_r   <= 64'd0;
              fill_r  <= 6'd0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/sm3_hash_engine.sv
// top level of the sm3 hash engine
`default_nettype none
// SM3 hash of a message streamed as big-endian 32-bit words; a word with
// in_final_word high closes the message and yields eight digest transactions,
// index 0 first. A word that does not complete a 64-byte block is only stored;
// the sixteenth word of a block is stored and then starts the single round
// unit, which runs one round per cycle through the 64 rounds. A final word
// whose padding fits its block is accepted, then the length is loaded and the
// rounds run; one whose padding spills needs two compressions with a
// padding-block load between them. Then the eight digest words are output,
// each held while the receiver stalls.
// A two-entry queue sits between the input side and the round engine.
module sm3_hash_engine (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_message_word,
  input  wire  [2:0]  in_valid_bytes,
  input  wire         in_final_word,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last
);
  import sm3_pkg::*;

  logic      q_valid, q_pop;
  sm3_item_t q_item;

  sm3_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_message_word, .in_valid_bytes,
    .in_final_word, .q_valid, .q_pop, .q_item
  );

  sm3_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
    .out_digest_word, .out_digest_index, .out_digest_last
  );
endmodule
`default_nettype wire
